[sv/checked_vm_memory_access_top_assert.svh]
// Assertion macros used by the back end of the checked memory unit.
`ifndef CHECKED_VM_MEMORY_ACCESS_TOP_ASSERT_SVH
`define CHECKED_VM_MEMORY_ACCESS_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CVMA_ASSERT_NOW(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("checked memory unit: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define CVMA_ASSERT_NEXT(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("checked memory unit: next-cycle check failed");

`endif

[sv/cvma_pkg.sv]
`timescale 1ns / 1ps

package cvma_pkg;

  // Default storage depth in cells, and the widest cell index supported.
  localparam int MEM_CELLS_DEF = 4096;
  localparam int IDX_W = 20;

  // Configuration data width and register indexes.
  localparam int CFG_W = 15;
  localparam logic [1:0] CFG_MEMORY_BYTES    = 2'd0;
  localparam logic [1:0] CFG_FLIP_BYTE_LANES = 2'd1;
  localparam logic [1:0] CFG_SWAP_ON_DMA     = 2'd2;

  localparam logic [CFG_W-1:0] MEMORY_BYTES_RESET = 15'd16384;
  localparam logic [31:0] FAULT_RESET = 32'h7FFF_FFFF;

  // Input kinds.
  localparam logic [2:0] KIND_LOAD_CELL  = 3'd0;
  localparam logic [2:0] KIND_LOAD_BYTE  = 3'd1;
  localparam logic [2:0] KIND_STORE_CELL = 3'd2;
  localparam logic [2:0] KIND_STORE_BYTE = 3'd3;
  localparam logic [2:0] KIND_DMA        = 3'd4;

  // Status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNALIGNED = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;
  localparam logic [1:0] ST_DMA       = 2'd3;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] address;
    logic [31:0] store_value;
    logic [31:0] range_end;
  } mem_in_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic [1:0]  status;
    logic [31:0] fault_address;
  } mem_out_t;

  // Memory operation that the back end carries out.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD_CELL,
    OP_LOAD_BYTE,
    OP_STORE_CELL,
    OP_STORE_BYTE,
    OP_SWAP
  } op_t;

  // Classified work item passed from the front end to the back end.
  typedef struct packed {
    op_t              op;
    logic [1:0]       status;
    logic [31:0]      fault;
    logic [IDX_W-1:0] idx;
    logic [1:0]       lane;
    logic [31:0]      wdata;
    logic [IDX_W:0]   count;
  } work_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_DATA
  } back_state_t;

  // Reverses the four bytes of a word.
  function automatic logic [31:0] swap_bytes(input logic [31:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

  // Extracts one byte lane of a word.
  function automatic logic [7:0] byte_get(input logic [31:0] w, input logic [1:0] lane);
    return w[{lane, 3'b000} +: 8];
  endfunction

  // Replaces one byte lane of a word.
  function automatic logic [31:0] byte_put(input logic [31:0] w, input logic [1:0] lane,
                                           input logic [7:0] b);
    logic [31:0] r;
    r = w;
    r[{lane, 3'b000} +: 8] = b;
    return r;
  endfunction

endpackage

[sv/cvma_ram.sv]
`timescale 1ns / 1ps

module cvma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/cvma_queue.sv]
`timescale 1ns / 1ps

module cvma_queue import cvma_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  work_t push_entry,
  output logic  full,
  input  logic  pop,
  output work_t pop_entry,
  output logic  empty
);

  logic [1:0] count;
  logic       head;
  logic       tail;
  work_t      ent [2];

  assign full      = (count == 2'd2);
  assign empty     = (count == 2'd0);
  assign pop_entry = ent[head];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      head  <= 1'b0;
      tail  <= 1'b0;
    end else begin
      if (push) begin
        tail <= ~tail;
      end
      if (pop) begin
        head <= ~head;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      ent[tail] <= push_entry;
    end
  end

endmodule

[sv/cvma_front.sv]
`timescale 1ns / 1ps

module cvma_front import cvma_pkg::*; #(
  parameter int MEM_CELLS = MEM_CELLS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  mem_in_t          item,
  input  logic             cfg_write,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             clearing,
  input  logic             q_full,
  output logic             push,
  output work_t            push_entry
);

  localparam int CW = $clog2(MEM_CELLS);
  localparam logic [32:0] PHYS_BYTES = 33'(MEM_CELLS) << 2;

  logic [CFG_W-1:0] memory_bytes;
  logic             flip_byte_lanes;
  logic             swap_on_dma;
  logic [31:0]      last_bad_address;
  logic [31:0]      fault_next;

  logic [32:0] lim;
  logic [31:0] byte_addr;
  logic        cell_unaligned;
  logic        cell_outside;
  logic        byte_outside;
  logic [31:0] dma_from;
  logic [31:0] dma_end_up;
  logic [31:0] dma_to;
  logic [31:0] dma_span;
  logic        dma_bad;

  // Accept only after the clearing pass and while the queue has room.
  assign busy = clearing || q_full;
  assign push = start && !busy;

  // Range bound and address checks.
  always_comb begin
    if ({18'b0, memory_bytes} < PHYS_BYTES) begin
      lim = {18'b0, memory_bytes};
    end else begin
      lim = PHYS_BYTES;
    end
    byte_addr      = flip_byte_lanes ? (item.address ^ 32'd3) : item.address;
    cell_unaligned = (item.address[1:0] != 2'b00);
    cell_outside   = (({1'b0, item.address} + 33'd4) > lim);
    byte_outside   = ({1'b0, byte_addr} >= lim);
    dma_from       = {item.address[31:2], 2'b00};
    dma_end_up     = item.range_end + 32'd3;
    dma_to         = {dma_end_up[31:2], 2'b00};
    dma_span       = dma_to - dma_from;
    dma_bad        = (dma_to < dma_from) || ({1'b0, dma_to} > lim);
  end

  // Classify the item into a memory operation and its status.
  always_comb begin
    fault_next        = last_bad_address;
    push_entry.op     = OP_NONE;
    push_entry.status = ST_OK;
    push_entry.idx    = '0;
    push_entry.lane   = 2'b00;
    push_entry.wdata  = item.store_value;
    push_entry.count  = '0;
    unique case (item.kind)
      KIND_LOAD_CELL, KIND_STORE_CELL: begin
        if (cell_unaligned) begin
          push_entry.status = ST_UNALIGNED;
          fault_next        = item.address;
        end else if (cell_outside) begin
          push_entry.status = ST_RANGE;
          fault_next        = item.address;
        end else begin
          push_entry.op  = (item.kind == KIND_LOAD_CELL) ? OP_LOAD_CELL : OP_STORE_CELL;
          push_entry.idx = IDX_W'(item.address[CW+1:2]);
        end
      end
      KIND_LOAD_BYTE, KIND_STORE_BYTE: begin
        if (byte_outside) begin
          push_entry.status = ST_RANGE;
          fault_next        = item.address;
        end else begin
          push_entry.op   = (item.kind == KIND_LOAD_BYTE) ? OP_LOAD_BYTE : OP_STORE_BYTE;
          push_entry.idx  = IDX_W'(byte_addr[CW+1:2]);
          push_entry.lane = byte_addr[1:0];
        end
      end
      KIND_DMA: begin
        if (dma_bad) begin
          push_entry.status = ST_DMA;
        end else if (swap_on_dma && (dma_span != 32'd0)) begin
          push_entry.op    = OP_SWAP;
          push_entry.idx   = IDX_W'(dma_from[CW+1:2]);
          push_entry.count = (IDX_W+1)'(dma_span[CW+2:2]);
        end
      end
      default: begin
      end
    endcase
    push_entry.fault = fault_next;
  end

  // Configuration registers and the fault address register.
  always_ff @(posedge clk) begin
    if (rst) begin
      memory_bytes     <= MEMORY_BYTES_RESET;
      flip_byte_lanes  <= 1'b0;
      swap_on_dma      <= 1'b0;
      last_bad_address <= FAULT_RESET;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_MEMORY_BYTES:    memory_bytes    <= cfg_data;
          CFG_FLIP_BYTE_LANES: flip_byte_lanes <= cfg_data[0];
          CFG_SWAP_ON_DMA:     swap_on_dma     <= cfg_data[0];
          default: begin
          end
        endcase
      end
      if (push) begin
        last_bad_address <= fault_next;
      end
    end
  end

endmodule

[sv/cvma_back.sv]
`timescale 1ns / 1ps
`include "checked_vm_memory_access_top_assert.svh"

module cvma_back import cvma_pkg::*; #(
  parameter int MEM_CELLS = MEM_CELLS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     q_empty,
  input  work_t    q_entry,
  output logic     pop,
  output logic     clearing,
  output logic     done,
  output mem_out_t result
);

  localparam int CW = $clog2(MEM_CELLS);

  back_state_t state;
  back_state_t state_next;
  logic [CW-1:0] clr_idx;
  work_t         cur;
  logic [CW-1:0] cur_idx;
  logic [CW:0]   remaining;
  logic          done_next;
  mem_out_t      result_next;

  logic          ram_we;
  logic [CW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic [CW-1:0] ram_raddr;
  logic [31:0]   ram_rdata;

  cvma_ram #(
    .WIDTH(32),
    .DEPTH(MEM_CELLS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign clearing = (state == BK_CLEAR);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      BK_CLEAR: begin
        if (clr_idx == CW'(MEM_CELLS - 1)) begin
          state_next = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (!q_empty && (q_entry.op == OP_LOAD_CELL || q_entry.op == OP_LOAD_BYTE ||
                         q_entry.op == OP_STORE_BYTE || q_entry.op == OP_SWAP)) begin
          state_next = BK_DATA;
        end
      end
      BK_DATA: begin
        if (cur.op != OP_SWAP || remaining == (CW+1)'(1)) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_CLEAR;
    endcase
  end

  // Memory port control and result formation.
  always_comb begin
    pop                       = 1'b0;
    ram_we                    = 1'b0;
    ram_waddr                 = cur_idx;
    ram_wdata                 = 32'd0;
    ram_raddr                 = cur_idx;
    done_next                 = 1'b0;
    result_next.read_value    = 32'd0;
    result_next.status        = cur.status;
    result_next.fault_address = cur.fault;
    unique case (state)
      BK_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx;
      end
      BK_IDLE: begin
        result_next.status        = q_entry.status;
        result_next.fault_address = q_entry.fault;
        ram_raddr                 = q_entry.idx[CW-1:0];
        if (!q_empty) begin
          pop = 1'b1;
          unique case (q_entry.op)
            OP_NONE: done_next = 1'b1;
            OP_STORE_CELL: begin
              ram_we    = 1'b1;
              ram_waddr = q_entry.idx[CW-1:0];
              ram_wdata = q_entry.wdata;
              done_next = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      BK_DATA: begin
        unique case (cur.op)
          OP_LOAD_CELL: begin
            result_next.read_value = ram_rdata;
            done_next              = 1'b1;
          end
          OP_LOAD_BYTE: begin
            result_next.read_value = {24'b0, byte_get(ram_rdata, cur.lane)};
            done_next              = 1'b1;
          end
          OP_STORE_BYTE: begin
            ram_we    = 1'b1;
            ram_wdata = byte_put(ram_rdata, cur.lane, cur.wdata[7:0]);
            done_next = 1'b1;
          end
          OP_SWAP: begin
            // Write back the reversed cell while the next one is read.
            ram_we    = 1'b1;
            ram_wdata = swap_bytes(ram_rdata);
            ram_raddr = cur_idx + CW'(1);
            done_next = (remaining == (CW+1)'(1));
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= BK_CLEAR;
      clr_idx <= '0;
      done    <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
      if (state == BK_CLEAR) begin
        clr_idx <= clr_idx + CW'(1);
      end
    end
  end

  // Work registers and the result payload.
  always_ff @(posedge clk) begin
    result <= result_next;
    if (pop) begin
      cur       <= q_entry;
      cur_idx   <= q_entry.idx[CW-1:0];
      remaining <= q_entry.count[CW:0];
    end else if (state == BK_DATA) begin
      cur_idx   <= cur_idx + CW'(1);
      remaining <= remaining - (CW+1)'(1);
    end
  end

  `CVMA_ASSERT_NOW(a_pop_has_entry, clk, rst, pop, !q_empty)
  `CVMA_ASSERT_NOW(a_quiet_while_clearing, clk, rst, state == BK_CLEAR, !pop && !done)
  `CVMA_ASSERT_NOW(a_fault_reads_zero, clk, rst, done && result.status != ST_OK, result.read_value == 32'd0)
  `CVMA_ASSERT_NEXT(a_swap_continues, clk, rst, state == BK_DATA && cur.op == OP_SWAP && remaining > (CW+1)'(1), state == BK_DATA)

endmodule

[sv/checked_vm_memory_access_top.sv]
`timescale 1ns / 1ps
// Flow: a taken item passes through the work queue; done is registered. Faults, DMA checks
// and cell stores finish from the back end's idle state; loads, byte stores and DMA swaps also
// use its data state, once per cell for a swap. Throughput: one item per cycle for faults and
// cell stores while the back end is idle; the data state waits on each registered memory read.
// Reset: a clearing pass zeroes all MEM_CELLS cells, one per cycle, with busy high;
// configuration writes are taken meanwhile. Results cannot be stalled by the receiver.

module checked_vm_memory_access_top import cvma_pkg::*; #(
  parameter int MEM_CELLS = MEM_CELLS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  mem_in_t          item,
  output logic             done,
  output mem_out_t         result,
  input  logic             cfg_write,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  logic  clearing;
  logic  q_full;
  logic  q_empty;
  logic  push;
  logic  pop;
  work_t push_entry;
  work_t pop_entry;

  // Front end: checks and classifies each item.
  cvma_front #(
    .MEM_CELLS(MEM_CELLS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .clearing  (clearing),
    .q_full    (q_full),
    .push      (push),
    .push_entry(push_entry)
  );

  // Work queue between the two ends.
  cvma_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .full      (q_full),
    .pop       (pop),
    .pop_entry (pop_entry),
    .empty     (q_empty)
  );

  // Back end: memory accesses and the DMA swap walk.
  cvma_back #(
    .MEM_CELLS(MEM_CELLS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_entry (pop_entry),
    .pop     (pop),
    .clearing(clearing),
    .done    (done),
    .result  (result)
  );

endmodule
